// File: src/in_circle_test_defines.svh
// Assertion macros for the incircle predicate block.
`ifndef IN_CIRCLE_TEST_DEFINES_SVH
`define IN_CIRCLE_TEST_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ICT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("in_circle_test: assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define ICT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("in_circle_test: assertion failed");

// Next-cycle implication that also holds across reset.
`define ICT_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("in_circle_test: assertion failed");

`endif

// File: src/ict_pkg.sv
// Shared types and constants for the incircle predicate pipeline.
`default_nettype none

package ict_pkg;

    localparam int ICT_STAGES = 10;
    localparam int ICT_LAST   = ICT_STAGES - 1;

    localparam logic signed [1:0] ICT_SIDE_POS  = 2'sd1;
    localparam logic signed [1:0] ICT_SIDE_ZERO = 2'sd0;
    localparam logic signed [1:0] ICT_SIDE_NEG  = -2'sd1;

    typedef struct packed {
        logic [ICT_STAGES-1:0] en;
        logic [ICT_STAGES-1:0] vld;
    } ict_pipe_t;

endpackage

`default_nettype wire

// File: src/ict_ctrl.sv
// Stage valid bits and load enables for the incircle pipeline.
`default_nettype none

module ict_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              m_ready,
    output ict_pkg::ict_pipe_t pipe
);
    import ict_pkg::*;

    logic [ICT_STAGES-1:0] vld_reg;
    logic [ICT_STAGES-1:0] vld_next;
    logic [ICT_STAGES-1:0] en;

    // A stage loads when it is empty or its item moves on; bubbles collapse.
    always_comb begin
        en[ICT_LAST] = !vld_reg[ICT_LAST] || m_ready;
        for (int k = ICT_STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        vld_next[0] = en[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < ICT_STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign pipe.en  = en;
    assign pipe.vld = vld_reg;

endmodule

`default_nettype wire

// File: src/ict_mul.sv
// Two-stage signed multiplier: b split into halves, partial products, then shift-add.
`default_nettype none

module ict_mul #(
    parameter int AW = 17,
    parameter int BW = 35
) (
    input  logic                    aclk,
    input  logic [1:0]              en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    localparam int LW  = BW / 2;
    localparam int HW  = BW - LW;
    localparam int PLW = AW + LW + 1;
    localparam int PHW = AW + HW;
    localparam int PW  = AW + BW;

    logic signed [PLW-1:0] plo_reg;
    logic signed [PHW-1:0] phi_reg;
    logic signed [PW-1:0]  p_reg;

    // Low half of b is unsigned, high half carries the sign.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            plo_reg <= a * $signed({1'b0, b[LW-1:0]});
            phi_reg <= a * $signed(b[BW-1:LW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p_reg <= (PW'(phi_reg) <<< LW) + PW'(plo_reg);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// File: src/in_circle_test.sv
// An accepted input passes through stages 0 to 9 before its result shows on m_valid/m_side.
// Throughput: one item per cycle while m_ready is high; ten register stages, each
// cofactor and final product split across a two-stage multiplier.
// Stalls collapse bubbles, so an input is taken whenever a stage frees up.
// Reset (aresetn low, synchronous) clears all stage valid bits; data registers
// are not reset.
`include "in_circle_test_defines.svh"
`default_nettype none

module in_circle_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_a_x,
    input  logic signed [COORD_BITS-1:0] s_a_y,
    input  logic signed [COORD_BITS-1:0] s_b_x,
    input  logic signed [COORD_BITS-1:0] s_b_y,
    input  logic signed [COORD_BITS-1:0] s_c_x,
    input  logic signed [COORD_BITS-1:0] s_c_y,
    input  logic signed [COORD_BITS-1:0] s_query_x,
    input  logic signed [COORD_BITS-1:0] s_query_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [1:0]            m_side
);
    import ict_pkg::*;

    localparam int DW   = COORD_BITS + 1;      // translated coordinate
    localparam int SQW  = 2 * DW;              // square or cross product
    localparam int NW   = 2 * COORD_BITS + 3;  // squared norm
    localparam int D3W  = 2 * COORD_BITS + 3;  // third cofactor
    localparam int CPW  = DW + NW;             // cofactor product
    localparam int D12W = CPW + 1;             // first and second cofactor
    localparam int FPW  = D12W + DW;           // final product
    localparam int DETW = 4 * COORD_BITS + 8;  // determinant

    ict_pipe_t pipe;

    ict_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .pipe    (pipe)
    );

    assign s_ready = pipe.en[0];
    assign m_valid = pipe.vld[ICT_LAST];

    // Stage 0: translate so that a is the origin.
    logic signed [DW-1:0] bx0_reg, by0_reg, cx0_reg, cy0_reg, dx0_reg, dy0_reg;

    always_ff @(posedge aclk) begin
        if (pipe.en[0]) begin
            bx0_reg <= DW'(s_b_x) - DW'(s_a_x);
            by0_reg <= DW'(s_b_y) - DW'(s_a_y);
            cx0_reg <= DW'(s_c_x) - DW'(s_a_x);
            cy0_reg <= DW'(s_c_y) - DW'(s_a_y);
            dx0_reg <= DW'(s_query_x) - DW'(s_a_x);
            dy0_reg <= DW'(s_query_y) - DW'(s_a_y);
        end
    end

    // Stage 1: squares and the cross products of the third cofactor.
    logic signed [SQW-1:0] bxx_reg, byy_reg, cxx_reg, cyy_reg, dxx_reg, dyy_reg;
    logic signed [SQW-1:0] bycx_reg, bxcy_reg;
    logic signed [DW-1:0]  bx1_reg, by1_reg, cx1_reg, cy1_reg, dx1_reg, dy1_reg;

    always_ff @(posedge aclk) begin
        if (pipe.en[1]) begin
            bxx_reg  <= bx0_reg * bx0_reg;
            byy_reg  <= by0_reg * by0_reg;
            cxx_reg  <= cx0_reg * cx0_reg;
            cyy_reg  <= cy0_reg * cy0_reg;
            dxx_reg  <= dx0_reg * dx0_reg;
            dyy_reg  <= dy0_reg * dy0_reg;
            bycx_reg <= by0_reg * cx0_reg;
            bxcy_reg <= bx0_reg * cy0_reg;
            bx1_reg  <= bx0_reg;
            by1_reg  <= by0_reg;
            cx1_reg  <= cx0_reg;
            cy1_reg  <= cy0_reg;
            dx1_reg  <= dx0_reg;
            dy1_reg  <= dy0_reg;
        end
    end

    // Stage 2: squared norms and the third cofactor.
    logic signed [NW-1:0]  bw2_reg, cw2_reg, dw2_reg;
    logic signed [D3W-1:0] d32_reg;
    logic signed [DW-1:0]  bx2_reg, by2_reg, cx2_reg, cy2_reg, dx2_reg, dy2_reg;

    always_ff @(posedge aclk) begin
        if (pipe.en[2]) begin
            bw2_reg <= NW'(bxx_reg) + NW'(byy_reg);
            cw2_reg <= NW'(cxx_reg) + NW'(cyy_reg);
            dw2_reg <= NW'(dxx_reg) + NW'(dyy_reg);
            d32_reg <= D3W'(bycx_reg) - D3W'(bxcy_reg);
            bx2_reg <= bx1_reg;
            by2_reg <= by1_reg;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
        end
    end

    // Stages 3 and 4: cofactor products.
    logic signed [CPW-1:0] cybw, bycw, bxcw, cxbw;

    ict_mul #(.AW(DW), .BW(NW)) u_mul_cybw (
        .aclk (aclk), .en (pipe.en[4:3]), .a (cy2_reg), .b (bw2_reg), .p (cybw)
    );
    ict_mul #(.AW(DW), .BW(NW)) u_mul_bycw (
        .aclk (aclk), .en (pipe.en[4:3]), .a (by2_reg), .b (cw2_reg), .p (bycw)
    );
    ict_mul #(.AW(DW), .BW(NW)) u_mul_bxcw (
        .aclk (aclk), .en (pipe.en[4:3]), .a (bx2_reg), .b (cw2_reg), .p (bxcw)
    );
    ict_mul #(.AW(DW), .BW(NW)) u_mul_cxbw (
        .aclk (aclk), .en (pipe.en[4:3]), .a (cx2_reg), .b (bw2_reg), .p (cxbw)
    );

    logic signed [DW-1:0]  dx3_reg, dy3_reg, dx4_reg, dy4_reg;
    logic signed [NW-1:0]  dw3_reg, dw4_reg;
    logic signed [D3W-1:0] d33_reg, d34_reg;

    always_ff @(posedge aclk) begin
        if (pipe.en[3]) begin
            dx3_reg <= dx2_reg;
            dy3_reg <= dy2_reg;
            dw3_reg <= dw2_reg;
            d33_reg <= d32_reg;
        end
        if (pipe.en[4]) begin
            dx4_reg <= dx3_reg;
            dy4_reg <= dy3_reg;
            dw4_reg <= dw3_reg;
            d34_reg <= d33_reg;
        end
    end

    // Stage 5: first and second cofactors.
    logic signed [D12W-1:0] d15_reg, d25_reg;
    logic signed [DW-1:0]   dx5_reg, dy5_reg;
    logic signed [NW-1:0]   dw5_reg;
    logic signed [D3W-1:0]  d35_reg;

    always_ff @(posedge aclk) begin
        if (pipe.en[5]) begin
            d15_reg <= D12W'(cybw) - D12W'(bycw);
            d25_reg <= D12W'(bxcw) - D12W'(cxbw);
            dx5_reg <= dx4_reg;
            dy5_reg <= dy4_reg;
            dw5_reg <= dw4_reg;
            d35_reg <= d34_reg;
        end
    end

    // Stages 6 and 7: final products.
    logic signed [FPW-1:0]      p1, p2;
    logic signed [D3W+NW-1:0]   p3;

    ict_mul #(.AW(DW), .BW(D12W)) u_mul_p1 (
        .aclk (aclk), .en (pipe.en[7:6]), .a (dx5_reg), .b (d15_reg), .p (p1)
    );
    ict_mul #(.AW(DW), .BW(D12W)) u_mul_p2 (
        .aclk (aclk), .en (pipe.en[7:6]), .a (dy5_reg), .b (d25_reg), .p (p2)
    );
    ict_mul #(.AW(D3W), .BW(NW)) u_mul_p3 (
        .aclk (aclk), .en (pipe.en[7:6]), .a (d35_reg), .b (dw5_reg), .p (p3)
    );

    // Stage 8: determinant.
    logic signed [DETW-1:0] det_reg;

    always_ff @(posedge aclk) begin
        if (pipe.en[8]) begin
            det_reg <= DETW'(p1) + DETW'(p2) + DETW'(p3);
        end
    end

    // Stage 9: sign into the output register.
    logic signed [1:0] side_reg;
    logic signed [1:0] side_next;

    always_comb begin
        priority if (det_reg[DETW-1]) begin
            side_next = ICT_SIDE_NEG;
        end else if (|det_reg) begin
            side_next = ICT_SIDE_POS;
        end else begin
            side_next = ICT_SIDE_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe.en[ICT_LAST]) begin
            side_reg <= side_next;
        end
    end

    assign m_side = side_reg;

    // An empty output stage frees every stage upstream of it.
    `ICT_ASSERT_NOW(a_empty_out_ready, !m_valid, s_ready)
    // Items in flight grow by one when an item enters and none leaves.
    `ICT_ASSERT_NEXT(a_item_count, (s_valid && s_ready && !(m_valid && m_ready)), ($countones(pipe.vld) == $past($countones(pipe.vld)) + 1))
    // No result is shown right after reset.
    `ICT_ASSERT_ALWAYS(a_reset_empty, !aresetn, !m_valid)

endmodule

`default_nettype wire

// File: test/tb_in_circle_test.sv
// Testbench for the in_circle_test incircle sign predicate, checked against a wide integer predictor.
`timescale 1ns / 1ps

module tb_in_circle_test;
    import ict_pkg::*;

    localparam int COORD_BITS  = 16;
    localparam int ITEMS       = 1200;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [127:0] det_t;

    typedef struct {
        coord_t ax, ay, bx, by, cx, cy, qx, qy;
    } points_t;

    // Holds the expected side of every accepted item and compares results in order.
    class side_checker;
        logic signed [1:0] expected_sides[$];
        int errors = 0;

        static function logic signed [1:0] incircle_side(points_t p);
            det_t bx, by, cx, cy, dx, dy, bn, cn, dn, m1, m2, m3, det;
            bx = $signed(p.bx) - $signed(p.ax);
            by = $signed(p.by) - $signed(p.ay);
            cx = $signed(p.cx) - $signed(p.ax);
            cy = $signed(p.cy) - $signed(p.ay);
            dx = $signed(p.qx) - $signed(p.ax);
            dy = $signed(p.qy) - $signed(p.ay);
            bn = bx * bx + by * by;
            cn = cx * cx + cy * cy;
            dn = dx * dx + dy * dy;
            m1 = cy * bn - by * cn;
            m2 = bx * cn - cx * bn;
            m3 = by * cx - bx * cy;
            det = m1 * dx + m2 * dy + m3 * dn;
            if (det > 0) begin
                return ICT_SIDE_POS;
            end else if (det == 0) begin
                return ICT_SIDE_ZERO;
            end
            return ICT_SIDE_NEG;
        endfunction

        function void note_points(points_t p);
            expected_sides.push_back(incircle_side(p));
        endfunction

        function void check_side(logic signed [1:0] got);
            logic signed [1:0] want;
            if (expected_sides.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d", $time, got);
                errors++;
                return;
            end
            want = expected_sides.pop_front();
            if (got !== want) begin
                $display("%0t: side mismatch, expected %0d, got %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    coord_t            s_a_x, s_a_y, s_b_x, s_b_y, s_c_x, s_c_y, s_query_x, s_query_y;
    logic              m_valid;
    logic              m_ready;
    logic signed [1:0] m_side;

    side_checker sides = new();
    bit          hold_req = 1'b0;
    int unsigned cycles = 0;

    in_circle_test #(
        .COORD_BITS(COORD_BITS)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_a_x     (s_a_x),
        .s_a_y     (s_a_y),
        .s_b_x     (s_b_x),
        .s_b_y     (s_b_y),
        .s_c_x     (s_c_x),
        .s_c_y     (s_c_y),
        .s_query_x (s_query_x),
        .s_query_y (s_query_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_side    (m_side)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_in_circle_test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sides.check_side(m_side);
        end
    end

    // Present one item and hold it until the block takes it.
    task automatic send_points(input points_t p);
        @(negedge aclk);
        s_a_x     <= p.ax;
        s_a_y     <= p.ay;
        s_b_x     <= p.bx;
        s_b_y     <= p.by;
        s_c_x     <= p.cx;
        s_c_y     <= p.cy;
        s_query_x <= p.qx;
        s_query_y <= p.qy;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sides.note_points(p);
    endtask

    task automatic send_coords(input int ax, ay, bx, by, cx, cy, qx, qy);
        points_t p;
        p.ax = coord_t'(ax); p.ay = coord_t'(ay); p.bx = coord_t'(bx); p.by = coord_t'(by);
        p.cx = coord_t'(cx); p.cy = coord_t'(cy); p.qx = coord_t'(qx); p.qy = coord_t'(qy);
        send_points(p);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    function automatic points_t random_points();
        points_t p;
        int kind, ox, oy, k, dx, dy, t1, t2, u, v, w, idx;
        int px[4];
        int py[4];
        int corner[7];
        corner = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        kind = $urandom_range(0, 9);
        p.ax = coord_t'($urandom); p.ay = coord_t'($urandom);
        p.bx = coord_t'($urandom); p.by = coord_t'($urandom);
        p.cx = coord_t'($urandom); p.cy = coord_t'($urandom);
        p.qx = coord_t'($urandom); p.qy = coord_t'($urandom);
        case (kind)
            4: begin
                p.ax = coord_t'(int'($urandom_range(0, 16)) - 8);
                p.ay = coord_t'(int'($urandom_range(0, 16)) - 8);
                p.bx = coord_t'(int'($urandom_range(0, 16)) - 8);
                p.by = coord_t'(int'($urandom_range(0, 16)) - 8);
                p.cx = coord_t'(int'($urandom_range(0, 16)) - 8);
                p.cy = coord_t'(int'($urandom_range(0, 16)) - 8);
                p.qx = coord_t'(int'($urandom_range(0, 16)) - 8);
                p.qy = coord_t'(int'($urandom_range(0, 16)) - 8);
            end
            5, 6: begin
                // four lattice points on one circle of radius 5k, d nudged off it at times
                ox = int'($urandom_range(0, 40000)) - 20000;
                oy = int'($urandom_range(0, 40000)) - 20000;
                k = $urandom_range(1, 2000);
                for (int i = 0; i < 4; i++) begin
                    idx = $urandom_range(0, 11);
                    case (idx % 3)
                        0: begin u = 5; v = 0; end
                        1: begin u = 3; v = 4; end
                        default: begin u = 4; v = 3; end
                    endcase
                    repeat (idx / 3) begin
                        w = u; u = -v; v = w;
                    end
                    px[i] = ox + u * k;
                    py[i] = oy + v * k;
                end
                if (kind == 6) begin
                    px[3] += ($urandom_range(0, 1) != 0) ? 1 : -1;
                    py[3] += int'($urandom_range(0, 2)) - 1;
                end
                p.ax = coord_t'(px[0]); p.ay = coord_t'(py[0]);
                p.bx = coord_t'(px[1]); p.by = coord_t'(py[1]);
                p.cx = coord_t'(px[2]); p.cy = coord_t'(py[2]);
                p.qx = coord_t'(px[3]); p.qy = coord_t'(py[3]);
            end
            7: begin
                // a, b and c on one line
                ox = int'($urandom_range(0, 20000)) - 10000;
                oy = int'($urandom_range(0, 20000)) - 10000;
                dx = int'($urandom_range(0, 200)) - 100;
                dy = int'($urandom_range(0, 200)) - 100;
                t1 = int'($urandom_range(0, 200)) - 100;
                t2 = int'($urandom_range(0, 200)) - 100;
                p.ax = coord_t'(ox); p.ay = coord_t'(oy);
                p.bx = coord_t'(ox + t1 * dx); p.by = coord_t'(oy + t1 * dy);
                p.cx = coord_t'(ox + t2 * dx); p.cy = coord_t'(oy + t2 * dy);
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: begin p.bx = p.ax; p.by = p.ay; end
                    1: begin p.cx = p.bx; p.cy = p.by; end
                    2: begin p.cx = p.ax; p.cy = p.ay; end
                    default: begin p.qx = p.bx; p.qy = p.by; end
                endcase
            end
            9: begin
                p.ax = coord_t'(corner[$urandom_range(0, 6)]);
                p.ay = coord_t'(corner[$urandom_range(0, 6)]);
                p.bx = coord_t'(corner[$urandom_range(0, 6)]);
                p.by = coord_t'(corner[$urandom_range(0, 6)]);
                p.cx = coord_t'(corner[$urandom_range(0, 6)]);
                p.cy = coord_t'(corner[$urandom_range(0, 6)]);
                p.qx = coord_t'(corner[$urandom_range(0, 6)]);
                p.qy = coord_t'(corner[$urandom_range(0, 6)]);
            end
            default: ;
        endcase
        return p;
    endfunction

    // Result side: runs of differing ready density, plus one long hold-off.
    initial begin
        int mode, len;
        bit held;
        m_ready = 1'b0;
        held = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end
            mode = $urandom_range(0, 3);
            len = $urandom_range(20, 150);
            repeat (len) begin
                @(negedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int burst, sent;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_a_x = '0; s_a_y = '0; s_b_x = '0; s_b_y = '0;
        s_c_x = '0; s_c_y = '0; s_query_x = '0; s_query_y = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // all points coincide
        send_coords(0, 0, 0, 0, 0, 0, 0, 0);
        // unit square corners lie on one circle
        send_coords(0, 0, 1, 0, 0, 1, 1, 1);
        // inside and outside, both orientations
        send_coords(0, 0, 4, 0, 0, 4, 1, 1);
        send_coords(0, 0, 4, 0, 0, 4, 10, 10);
        send_coords(0, 0, 0, 4, 4, 0, 1, 1);
        send_coords(0, 0, 0, 4, 4, 0, 10, 10);
        send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        // full-range square and points near its circle
        send_coords(-32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767);
        send_coords(-32768, -32768, 32767, -32768, 32767, 32767, 0, 0);
        send_coords(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32766);
        send_coords(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768);
        send_coords(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
        // degenerate circles: collinear and repeated points
        send_coords(0, 0, 100, 100, -200, -200, 5, -7);
        send_coords(10, 20, 300, -400, 300, -400, -9, 8);
        send_coords(-5, 7, -5, 7, 1000, 2000, 3, 3);
        send_coords(1, 2, 30, 40, -50, 60, 1, 2);
        send_coords(1, 2, 30, 40, -50, 60, 30, 40);
        // Pythagorean points on radius 5, then just outside and inside
        send_coords(5, 0, 3, 4, -4, 3, 0, -5);
        send_coords(5, 0, 3, 4, -4, 3, 0, -6);
        send_coords(5, 0, 3, 4, -4, 3, 0, -4);
        send_coords(21845, -21846, -21846, 21845, 21845, 21845, -21846, -21846);
        send_coords(-21846, 21845, 21845, -21846, -1, 1, 1, -1);

        sent = 0;
        while (sent < ITEMS) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if (sent < ITEMS) begin
                    send_points(random_points());
                    sent++;
                    if (sent == 200) hold_req = 1'b1;
                end
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
        end
        pause_sender(1);

        while (sides.expected_sides.size() != 0) @(posedge aclk);
        repeat (ICT_STAGES + 10) @(posedge aclk);
        if (sides.errors == 0 && sides.expected_sides.size() == 0) begin
            $display("tb_in_circle_test passed");
        end else begin
            $display("tb_in_circle_test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/ict_pkg.sv
src/ict_ctrl.sv
src/ict_mul.sv
src/in_circle_test.sv
test/tb_in_circle_test.sv
